/* hw/rtl/wlm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// wlm_pkg: shared types, codes and byte helpers of the wildcard matcher
// used by wlm_cmp and wildcard_like_matcher; depends on nothing

package wlm_pkg;

  // request commands
  typedef enum logic [1:0] {
    CMD_PAT  = 2'd0,
    CMD_SUBJ = 2'd1,
    CMD_EVAL = 2'd2,
    CMD_CLR  = 2'd3
  } cmd_t;

  // match sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EXEC = 2'd2,
    ST_FIN  = 2'd3
  } state_t;

  localparam logic [7:0] PCT_BYTE = 8'h25;
  localparam logic [7:0] ANY_BYTE = 8'h5F;
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] UC_FIRST = 8'h41;
  localparam logic [7:0] UC_LAST  = 8'h5A;
  localparam logic [7:0] FOLD_ADD = 8'h20;

  // compare unit result
  typedef struct packed {
    logic is_pct;
    logic is_any;
    logic eq;
  } cmp_t;

  // ascii upper case to lower case
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    if (b >= UC_FIRST && b <= UC_LAST) begin
      return b + FOLD_ADD;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/wlm_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// wlm_mem: byte store with one write port and one registered read port
// holds the pattern or the subject; no dependencies

module wlm_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/wlm_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none
// wlm_cmp: shared byte compare unit of the matcher
// classifies the pattern byte and compares it with the subject byte; uses wlm_pkg

module wlm_cmp (
  input  wire logic [7:0] pat_byte,
  input  wire logic [7:0] subj_byte,
  input  wire logic       case_sens,
  output wlm_pkg::cmp_t   res
);

  import wlm_pkg::*;

  // wildcard decode and exact or folded compare
  always_comb begin
    res.is_pct = (pat_byte == PCT_BYTE);
    res.is_any = (pat_byte == ANY_BYTE);
    if (case_sens) begin
      res.eq = (pat_byte == subj_byte);
    end else begin
      res.eq = (fold_byte(pat_byte) == fold_byte(subj_byte));
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/wildcard_like_matcher.sv */
`timescale 1ns / 1ps
// SQL LIKE / ILIKE matcher. Requests append pattern bytes, append subject
// bytes, evaluate, or clear the pattern. An evaluate walks both byte stores
// with the greedy single-backtrack wildcard search; each step reads one
// pattern byte and one subject byte from the stores in ST_READ and runs them
// through one compare unit in ST_EXEC. An evaluate goes straight to ST_FIN
// when a store overflowed. in_tready is low while an evaluate runs. The
// result sits in an output register, so appends are taken while a result
// waits. An evaluate clears the subject; the pattern stays until a clear
// request. No clearing pass is needed after reset.
`default_nettype none

module wildcard_like_matcher #(
  parameter int MAX_LEN = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // case mode: 1 exact, 0 letters folded
  // requests
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,      // [1:0] command, [9:2] char_byte, rest zero
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata      // [0] matched, [1] overflow, rest zero
);

  import wlm_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
  localparam logic [LW-1:0] LEN_ONE = LW'(1);

  state_t        state_r, state_nxt;
  logic          case_sens_r;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [LW-1:0] slen_r, slen_nxt;
  logic          pov_r, pov_nxt;
  logic          sov_r, sov_nxt;
  logic [LW-1:0] pi_r, pi_nxt;
  logic [LW-1:0] si_r, si_nxt;
  logic [LW-1:0] star_r, star_nxt;
  logic [LW-1:0] resume_r, resume_nxt;
  logic          have_star_r, have_star_nxt;
  logic          hit_r, hit_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_match_r, out_match_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          accept;
  cmd_t          cmd;
  logic [7:0]    char_byte;
  logic          pat_we, subj_we;
  logic [7:0]    pat_rd, subj_rd;
  cmp_t          cmp;
  logic          p_in;

  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tdata[1:0]);
  assign char_byte = in_tdata[9:2];
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_ovf_r, out_match_r};

  // byte stores
  wlm_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_pat_mem (
    .clk     (clk),
    .wr_en   (pat_we),
    .wr_addr (plen_r[AW-1:0]),
    .wr_data (char_byte),
    .rd_addr (pi_r[AW-1:0]),
    .rd_data (pat_rd)
  );

  wlm_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_subj_mem (
    .clk     (clk),
    .wr_en   (subj_we),
    .wr_addr (slen_r[AW-1:0]),
    .wr_data (char_byte),
    .rd_addr (si_r[AW-1:0]),
    .rd_data (subj_rd)
  );

  // shared compare unit
  wlm_cmp u_cmp (
    .pat_byte  (pat_rd),
    .subj_byte (subj_rd),
    .case_sens (case_sens_r),
    .res       (cmp)
  );

  assign p_in = (pi_r < plen_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_sens_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case_sens_r <= cfg_wr_data;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plen_r      <= '0;
      slen_r      <= '0;
      pov_r       <= 1'b0;
      sov_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      slen_r      <= slen_nxt;
      pov_r       <= pov_nxt;
      sov_r       <= sov_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search registers and result payload
  always_ff @(posedge clk) begin
    pi_r        <= pi_nxt;
    si_r        <= si_nxt;
    star_r      <= star_nxt;
    resume_r    <= resume_nxt;
    have_star_r <= have_star_nxt;
    hit_r       <= hit_nxt;
    ovf_r       <= ovf_nxt;
    out_match_r <= out_match_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // sequencer: loads, search steps and result hand-off
  always_comb begin
    state_nxt     = state_r;
    plen_nxt      = plen_r;
    slen_nxt      = slen_r;
    pov_nxt       = pov_r;
    sov_nxt       = sov_r;
    pi_nxt        = pi_r;
    si_nxt        = si_r;
    star_nxt      = star_r;
    resume_nxt    = resume_r;
    have_star_nxt = have_star_r;
    hit_nxt       = hit_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_match_nxt = out_match_r;
    out_ovf_nxt   = out_ovf_r;
    pat_we        = 1'b0;
    subj_we       = 1'b0;

    // result leaves the output register
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_PAT: begin
              if (char_byte != NUL_BYTE) begin
                if (plen_r < LEN_MAX) begin
                  pat_we   = 1'b1;
                  plen_nxt = plen_r + LEN_ONE;
                end else begin
                  pov_nxt = 1'b1;
                end
              end
            end
            CMD_SUBJ: begin
              if (char_byte != NUL_BYTE) begin
                if (slen_r < LEN_MAX) begin
                  subj_we  = 1'b1;
                  slen_nxt = slen_r + LEN_ONE;
                end else begin
                  sov_nxt = 1'b1;
                end
              end
            end
            CMD_EVAL: begin
              pi_nxt        = '0;
              si_nxt        = '0;
              star_nxt      = '0;
              resume_nxt    = '0;
              have_star_nxt = 1'b0;
              hit_nxt       = 1'b0;
              ovf_nxt       = pov_r || sov_r;
              state_nxt     = (pov_r || sov_r) ? ST_FIN : ST_READ;
            end
            CMD_CLR: begin
              plen_nxt = '0;
              pov_nxt  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      // store addresses are presented, bytes come back next cycle
      ST_READ: begin
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        state_nxt = ST_READ;
        if (si_r < slen_r) begin
          // main walk with backtrack to the last percent sign
          priority if (p_in && cmp.is_pct) begin
            have_star_nxt = 1'b1;
            star_nxt      = pi_r;
            pi_nxt        = pi_r + LEN_ONE;
            resume_nxt    = si_r;
          end else if (p_in && (cmp.is_any || cmp.eq)) begin
            si_nxt = si_r + LEN_ONE;
            pi_nxt = pi_r + LEN_ONE;
          end else if (have_star_r) begin
            pi_nxt     = star_r + LEN_ONE;
            resume_nxt = resume_r + LEN_ONE;
            si_nxt     = resume_r + LEN_ONE;
          end else begin
            hit_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end
        end else begin
          // subject used up: skip trailing percent signs
          if (p_in && cmp.is_pct) begin
            pi_nxt = pi_r + LEN_ONE;
          end else begin
            hit_nxt   = !p_in;
            state_nxt = ST_FIN;
          end
        end
      end

      // load result once the output register is free, clear the subject
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = hit_r && !ovf_r;
          out_ovf_nxt   = ovf_r;
          slen_nxt      = '0;
          sov_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
